FILE: hdl/r2a_pkg.sv
// Package: shared widths, ASCII constants and the request/response types of the converter.
`default_nettype none
package r2a_pkg;

  localparam int VALUE_WIDTH   = 32;
  localparam int RADIX_W       = 6;
  localparam int DIGIT_W       = 6;
  localparam int CHAR_W        = 7;
  localparam int IDX_W         = $clog2(VALUE_WIDTH);
  localparam int LVL_W         = $clog2(VALUE_WIDTH + 1);

  localparam logic [RADIX_W-1:0] RADIX_MIN     = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX     = 6'd36;
  localparam logic [CHAR_W-1:0]  ASCII_ZERO    = 7'd48;
  localparam logic [CHAR_W-1:0]  ASCII_A       = 7'd65;
  localparam logic [DIGIT_W-1:0] DECIMAL_TOP   = 6'd9;
  localparam logic [CHAR_W-1:0]  LETTER_OFFSET = 7'd10;

  typedef struct packed {
    logic [VALUE_WIDTH-1:0] value;
    logic [RADIX_W-1:0]     radix;
  } in_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] digit_char;
    logic              last;
    logic              bad_base;
  } out_item_t;

  typedef struct packed {
    logic                   start;
    logic [VALUE_WIDTH-1:0] dividend;
    logic [RADIX_W-1:0]     divisor;
  } div_req_t;

  typedef struct packed {
    logic                   done;
    logic [VALUE_WIDTH-1:0] quotient;
    logic [DIGIT_W-1:0]     remainder;
  } div_res_t;

  typedef struct packed {
    logic               push;
    logic               pop;
    logic [DIGIT_W-1:0] digit;
  } stk_ctl_t;

  typedef struct packed {
    logic [DIGIT_W-1:0] top_digit;
    logic [LVL_W-1:0]   level;
  } stk_stat_t;

  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] dx;
    dx = {1'b0, d};
    if (d > DECIMAL_TOP) begin
      return dx - LETTER_OFFSET + ASCII_A;
    end
    return dx + ASCII_ZERO;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/r2a_divider.sv
// Restoring divider: one quotient bit per cycle, value by radix.
`default_nettype none
module r2a_divider (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire r2a_pkg::div_req_t req,
  output r2a_pkg::div_res_t      res
);

  logic [r2a_pkg::VALUE_WIDTH-1:0] q_r, q_nxt;
  logic [r2a_pkg::DIGIT_W-1:0]     rem_r, rem_nxt;
  logic [r2a_pkg::RADIX_W-1:0]     div_r;
  logic [r2a_pkg::IDX_W-1:0]       cnt_r;
  logic                            run_r;
  logic                            done_r;
  logic [r2a_pkg::DIGIT_W:0]       trial;
  logic                            fits;

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  always_comb begin
    trial   = {rem_r, q_r[r2a_pkg::VALUE_WIDTH-1]};
    fits    = trial >= {1'b0, div_r};
    rem_nxt = fits ? r2a_pkg::DIGIT_W'(trial - {1'b0, div_r})
                   : r2a_pkg::DIGIT_W'(trial);
    q_nxt   = {q_r[r2a_pkg::VALUE_WIDTH-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        run_r <= 1'b1;
        cnt_r <= r2a_pkg::IDX_W'(r2a_pkg::VALUE_WIDTH - 1);
      end else if (run_r) begin
        cnt_r <= cnt_r - r2a_pkg::IDX_W'(1);
        if (cnt_r == '0) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      q_r   <= req.dividend;
      rem_r <= '0;
      div_r <= req.divisor;
    end else if (run_r) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign res.done      = done_r;
  assign res.quotient  = q_r;
  assign res.remainder = rem_r;

endmodule
`default_nettype wire

FILE: hdl/r2a_digit_stack.sv
// Digit stack: remainders pushed least significant first, popped most significant first.
`default_nettype none
module r2a_digit_stack (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire r2a_pkg::stk_ctl_t ctl,
  output r2a_pkg::stk_stat_t     stat
);

  logic [r2a_pkg::DIGIT_W-1:0] mem [r2a_pkg::VALUE_WIDTH];
  logic [r2a_pkg::LVL_W-1:0]   level_r;
  logic [r2a_pkg::LVL_W-1:0]   lvl_dec;
  logic [r2a_pkg::LVL_W-1:0]   lvl_below;
  logic [r2a_pkg::DIGIT_W-1:0] top_r;

  assign lvl_dec   = level_r - r2a_pkg::LVL_W'(1);
  assign lvl_below = level_r - r2a_pkg::LVL_W'(2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= '0;
    end else if (ctl.push) begin
      level_r <= level_r + r2a_pkg::LVL_W'(1);
    end else if (ctl.pop) begin
      level_r <= lvl_dec;
    end
  end

  // Track the top entry in a register: load it on push, fetch the one below on pop.
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[level_r[r2a_pkg::IDX_W-1:0]] <= ctl.digit;
      top_r                            <= ctl.digit;
    end else if (ctl.pop) begin
      top_r <= mem[lvl_below[r2a_pkg::IDX_W-1:0]];
    end
  end

  assign stat.top_digit = top_r;
  assign stat.level     = level_r;

endmodule
`default_nettype wire

FILE: hdl/radix_integer_to_ascii.sv
// Top level: radix integer-to-ASCII converter with sequencer and output register.
//
// Usage:
//   Raise start with in_data (value, radix) while busy is low; the request is
//   taken at that clock edge. Digits come out on out_data, most significant
//   first, one per cycle with out_strobe high; the final digit has last set.
//   A value of zero gives the single digit '0'.
//   A radix outside 2 to 36 gives one result (digit_char 0, last 1, bad_base 1)
//   in the cycle after the request; busy stays low for it.
// Sequence:
//   The one restoring divider yields one digit per division, and the digits
//   are stacked least significant first. Once the quotient is zero they come
//   out back to back, and busy falls with the last digit. Radix 2 gives the
//   longest string, VALUE_WIDTH digits.
// Reset:
//   rst_n is synchronous, active low; it drops any request in progress and
//   clears the strobe. The receiver cannot stall: each result is valid for
//   exactly one cycle.
`default_nettype none
module radix_integer_to_ascii (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire r2a_pkg::in_item_t in_data,
  output logic                   out_strobe,
  output r2a_pkg::out_item_t     out_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]                    state_r, state_nxt;
  logic                          out_strobe_r, out_strobe_nxt;
  r2a_pkg::out_item_t            out_data_r, out_data_nxt;
  r2a_pkg::div_req_t             div_req;
  r2a_pkg::div_res_t             div_res;
  r2a_pkg::stk_ctl_t             stk_ctl;
  r2a_pkg::stk_stat_t            stk_stat;
  logic                          accept;
  logic                          radix_ok;
  logic [r2a_pkg::RADIX_W-1:0]   radix_r;

  r2a_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .res   (div_res)
  );

  r2a_digit_stack u_stack (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (stk_ctl),
    .stat  (stk_stat)
  );

  assign busy     = (state_r != ST_IDLE);
  assign accept   = start && !busy;
  assign radix_ok = (in_data.radix >= r2a_pkg::RADIX_MIN) &&
                    (in_data.radix <= r2a_pkg::RADIX_MAX);

  // Sequencer: flag a bad radix at once; otherwise divide until the quotient is zero, then drain the stack.
  always_comb begin
    state_nxt        = state_r;
    out_strobe_nxt   = 1'b0;
    out_data_nxt     = out_data_r;
    div_req.start    = 1'b0;
    div_req.dividend = div_res.quotient;
    div_req.divisor  = radix_r;
    stk_ctl.push     = 1'b0;
    stk_ctl.pop      = 1'b0;
    stk_ctl.digit    = div_res.remainder;
    unique case (state_r)
      ST_IDLE: begin
        div_req.dividend = in_data.value;
        div_req.divisor  = in_data.radix;
        if (accept) begin
          if (radix_ok) begin
            // Launch the first division on the raw value.
            div_req.start = 1'b1;
            state_nxt     = ST_DIV;
          end else begin
            // Flag the bad radix in one result and stay idle.
            out_strobe_nxt          = 1'b1;
            out_data_nxt.digit_char = '0;
            out_data_nxt.last       = 1'b1;
            out_data_nxt.bad_base   = 1'b1;
          end
        end
      end
      ST_DIV: begin
        if (div_res.done) begin
          // Push the remainder; continue on the quotient unless it is zero.
          stk_ctl.push = 1'b1;
          if (div_res.quotient == '0) begin
            state_nxt = ST_EMIT;
          end else begin
            div_req.start = 1'b1;
          end
        end
      end
      ST_EMIT: begin
        // Pop one digit a cycle, most significant first.
        stk_ctl.pop             = 1'b1;
        out_strobe_nxt          = 1'b1;
        out_data_nxt.digit_char = r2a_pkg::digit_to_ascii(stk_stat.top_digit);
        out_data_nxt.last       = (stk_stat.level == r2a_pkg::LVL_W'(1));
        out_data_nxt.bad_base   = 1'b0;
        if (stk_stat.level == r2a_pkg::LVL_W'(1)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  // Hold the radix for the later divisions; payload needs no reset.
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (accept) begin
      radix_r <= in_data.radix;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

`ifndef NO_ASSERTIONS
  a_emit_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> (stk_stat.level != '0))
    else $error("emit with empty digit stack");

  a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (stk_stat.level <= r2a_pkg::LVL_W'(r2a_pkg::VALUE_WIDTH)))
    else $error("digit stack overflow");

  a_digit_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_data.bad_base) |-> ($past(state_r) == ST_EMIT))
    else $error("digit result outside emit phase");

  a_bad_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_data.bad_base) |-> (out_data.last && (out_data.digit_char == '0)))
    else $error("bad radix result malformed");

  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_data.last && !out_data.bad_base) |-> (state_r == ST_IDLE))
    else $error("sequencer busy after final digit");
`endif

endmodule
`default_nettype wire

FILE: bench/radix_integer_to_ascii_tb.sv
// Testbench for the radix integer-to-ASCII converter: directed and random requests, self-checked.
`timescale 1ns / 100ps
module radix_integer_to_ascii_tb;

  // Quiet cycles after the last digit: enough for a stray extra digit to show.
  localparam int SETTLE_CYCLES = 2 * (r2a_pkg::VALUE_WIDTH + 2);

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  r2a_pkg::in_item_t  in_data = '0;
  logic               busy;
  logic               out_strobe;
  r2a_pkg::out_item_t out_data;

  // Digits still owed by the block, oldest first.
  r2a_pkg::out_item_t digits_due[$];
  int unsigned        error_count = 0;

  radix_integer_to_ascii dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_strobe(out_strobe),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  // Work out the digit string of one request and queue it, most significant
  // digit first. An out-of-range radix owes one flagged result instead.
  function automatic void predict_digits(input logic [r2a_pkg::VALUE_WIDTH-1:0] value,
                                         input logic [r2a_pkg::RADIX_W-1:0] radix);
    logic [r2a_pkg::DIGIT_W-1:0]     lsd_first [r2a_pkg::VALUE_WIDTH];
    logic [r2a_pkg::VALUE_WIDTH-1:0] rest;
    int                              n;
    r2a_pkg::out_item_t              item;
    if (radix < r2a_pkg::RADIX_MIN || radix > r2a_pkg::RADIX_MAX) begin
      item.digit_char = '0;
      item.last       = 1'b1;
      item.bad_base   = 1'b1;
      digits_due.push_back(item);
      return;
    end
    rest = value;
    n    = 0;
    // Peel digits off the low end; zero still yields one digit.
    do begin
      lsd_first[n] = r2a_pkg::DIGIT_W'(rest % radix);
      rest         = rest / radix;
      n++;
    end while (rest != 0);
    for (int k = n - 1; k >= 0; k--) begin
      if (lsd_first[k] > r2a_pkg::DECIMAL_TOP) begin
        item.digit_char = r2a_pkg::CHAR_W'(lsd_first[k]) - r2a_pkg::LETTER_OFFSET
                          + r2a_pkg::ASCII_A;
      end else begin
        item.digit_char = r2a_pkg::CHAR_W'(lsd_first[k]) + r2a_pkg::ASCII_ZERO;
      end
      item.last     = (k == 0);
      item.bad_base = 1'b0;
      digits_due.push_back(item);
    end
  endfunction

  // Mostly back-to-back, sometimes a short gap, rarely a long gap.
  function automatic int random_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 65) return 0;
    if (pick < 95) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  // Any radix the block must flag: 0, 1 or 37..63.
  function automatic logic [r2a_pkg::RADIX_W-1:0] random_bad_radix();
    int pick;
    pick = $urandom_range(0, 28);
    return (pick < 2) ? r2a_pkg::RADIX_W'(pick) : r2a_pkg::RADIX_W'(pick + 35);
  endfunction

  // Present one request and hold it until the block takes it. Start is left
  // high so a back-to-back request never lowers and raises it in one step.
  task automatic send_request(input logic [r2a_pkg::VALUE_WIDTH-1:0] value,
                              input logic [r2a_pkg::RADIX_W-1:0] radix);
    start   <= 1'b1;
    in_data <= {value, radix};
    do @(posedge clk); while (busy);
    predict_digits(value, radix);
  endtask

  // Drop start for a number of cycles; zero keeps the request stream tight.
  task automatic hold_off(input int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Drop start and wait until every owed digit has come out.
  task automatic drain_digits();
    start <= 1'b0;
    while (digits_due.size() != 0) @(posedge clk);
  endtask

  // Compare each strobed digit with the oldest owed one. Outputs are read
  // before this edge's updates land, so the order of events does not matter.
  always @(posedge clk) begin
    r2a_pkg::out_item_t want;
    if (rst_n && out_strobe) begin
      if (digits_due.size() == 0) begin
        $error("unexpected digit: digit_char %0d last %0b bad_base %0b",
               out_data.digit_char, out_data.last, out_data.bad_base);
        error_count++;
      end else begin
        want = digits_due.pop_front();
        if (out_data.digit_char !== want.digit_char) begin
          $error("digit_char: expected %0d, got %0d", want.digit_char, out_data.digit_char);
          error_count++;
        end
        if (out_data.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, out_data.last);
          error_count++;
        end
        if (out_data.bad_base !== want.bad_base) begin
          $error("bad_base: expected %0b, got %0b", want.bad_base, out_data.bad_base);
          error_count++;
        end
      end
    end
  end

  // Field extremes, zero, letter digits, the longest string and bad radices.
  task automatic test_directed();
    send_request('0, 6'd10);                hold_off(random_gap());
    send_request('0, 6'd2);                 hold_off(random_gap());
    send_request('0, 6'd36);                hold_off(random_gap());
    send_request('1, 6'd2);                 hold_off(random_gap());  // 32 ones
    send_request('1, 6'd10);                hold_off(random_gap());
    send_request('1, 6'd16);                hold_off(random_gap());
    send_request('1, 6'd36);                hold_off(random_gap());
    send_request(32'd1, 6'd2);              hold_off(random_gap());
    send_request(32'h8000_0000, 6'd2);      hold_off(random_gap());
    send_request(32'd35, 6'd36);            hold_off(random_gap());  // single 'Z'
    send_request(32'd36, 6'd36);            hold_off(random_gap());  // "10"
    send_request(32'd9, 6'd10);             hold_off(random_gap());
    send_request(32'd10, 6'd16);            hold_off(random_gap());  // single 'A'
    send_request(32'd255, 6'd16);           hold_off(random_gap());
    send_request(32'd1234567890, 6'd10);    hold_off(random_gap());
    send_request(32'd42, 6'd3);             hold_off(random_gap());
    send_request(32'hDEAD_BEEF, 6'd7);      hold_off(random_gap());
    send_request(32'd5, 6'd0);              hold_off(random_gap());
    send_request(32'd5, 6'd1);              hold_off(random_gap());
    send_request('1, 6'd37);                hold_off(random_gap());
    send_request('0, 6'd63);                hold_off(random_gap());
    send_request(32'd12345, 6'd63);
    drain_digits();
  endtask

  // Flagged requests leave busy low, so they can follow one another every
  // cycle; then a real conversion straight behind them and one more flagged request.
  task automatic test_bad_radix_stream();
    for (int i = 0; i < 12; i++) begin
      send_request($urandom(), random_bad_radix());
    end
    send_request($urandom(), 6'd10);
    send_request($urandom(), random_bad_radix());
    drain_digits();
  endtask

  // Let the block run dry between requests.
  task automatic test_idle_between();
    for (int i = 0; i < 5; i++) begin
      send_request($urandom(), r2a_pkg::RADIX_W'($urandom_range(2, 36)));
      drain_digits();
    end
  endtask

  // Random requests of all lengths; a shift of the value spreads the digit
  // count. Every 25 requests, toggle a stretch with no gaps at all.
  task automatic test_random();
    logic [r2a_pkg::VALUE_WIDTH-1:0] value;
    logic [r2a_pkg::RADIX_W-1:0]     radix;
    bit                              tight;
    tight = 1'b0;
    for (int i = 0; i < 400; i++) begin
      if (i % 25 == 0) tight = ~tight;
      value = $urandom() >> $urandom_range(0, r2a_pkg::VALUE_WIDTH - 1);
      if ($urandom_range(0, 99) < 8) begin
        radix = random_bad_radix();
      end else begin
        radix = r2a_pkg::RADIX_W'($urandom_range(2, 36));
      end
      send_request(value, radix);
      hold_off(tight ? 0 : random_gap());
    end
    drain_digits();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_bad_radix_stream();
    test_idle_between();
    test_random();
    // Watch for stray digits after the last one owed.
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // The worst case is about 450 requests, all at radix 2; allow several times
  // that before declaring a hang.
  initial begin
    #25_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
